/* hdl/e2r_pkg.sv */
// e2r_pkg: shared constants, types and functions for the Euler angle to
// rotation matrix block. No dependencies.
`default_nettype none
package e2r_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int N_STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int ANG_W = 16;
    localparam int OUT_W = 16;
    localparam int CW = 33;
    localparam int ZW = 28;
    localparam int PW = 2 * CW;

    localparam logic signed [16:0] DEG360 = 17'sd46080;
    localparam logic signed [16:0] DEG270 = 17'sd34560;
    localparam logic signed [16:0] DEG180 = 17'sd23040;
    localparam logic signed [16:0] DEG90 = 17'sd11520;
    localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [OUT_W-1:0] ONE_Q14 = 16'sd16384;

    typedef logic signed [ANG_W-1:0] t_angle;
    typedef logic signed [OUT_W-1:0] t_q14;
    typedef logic signed [CW-1:0] t_q30;
    typedef logic signed [ZW-1:0] t_zang;

    typedef struct packed {
        t_angle yaw_angle;
        t_angle pitch_angle;
        t_angle roll_angle;
    } t_in_item;

    typedef struct packed {
        t_q14 r00; t_q14 r01; t_q14 r02;
        t_q14 r10; t_q14 r11; t_q14 r12;
        t_q14 r20; t_q14 r21; t_q14 r22;
    } t_out_item;

    typedef struct packed {
        t_q30 cs;
        t_q30 sn;
    } t_trig;

    function automatic t_zang atan_q20(input int idx);
        case (idx)
            0: atan_q20 = 28'sd47185920;
            1: atan_q20 = 28'sd27855475;
            2: atan_q20 = 28'sd14718068;
            3: atan_q20 = 28'sd7471121;
            4: atan_q20 = 28'sd3750058;
            5: atan_q20 = 28'sd1876857;
            6: atan_q20 = 28'sd938658;
            7: atan_q20 = 28'sd469357;
            8: atan_q20 = 28'sd234682;
            9: atan_q20 = 28'sd117342;
            10: atan_q20 = 28'sd58671;
            11: atan_q20 = 28'sd29335;
            12: atan_q20 = 28'sd14668;
            13: atan_q20 = 28'sd7334;
            14: atan_q20 = 28'sd3667;
            15: atan_q20 = 28'sd1833;
            16: atan_q20 = 28'sd917;
            17: atan_q20 = 28'sd458;
            18: atan_q20 = 28'sd229;
            19: atan_q20 = 28'sd115;
            20: atan_q20 = 28'sd57;
            21: atan_q20 = 28'sd29;
            22: atan_q20 = 28'sd14;
            default: atan_q20 = 28'sd7;
        endcase
    endfunction

    function automatic t_q30 rnd30(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p + (PW'(1) <<< 29);
        rnd30 = CW'(s >>> 30);
    endfunction

    function automatic t_q14 to_q14(input logic signed [CW:0] v);
        logic signed [CW:0] r;
        r = (v + (CW+1)'(32768)) >>> 16;
        if (r > (CW+1)'(ONE_Q14)) to_q14 = ONE_Q14;
        else if (r < -(CW+1)'(ONE_Q14)) to_q14 = -ONE_Q14;
        else to_q14 = OUT_W'(r);
    endfunction

endpackage
`default_nettype wire

/* hdl/e2r_if.sv */
// e2r_in_if, e2r_out_if: valid/ready channels carrying one item of type t_in_item or t_out_item.
// Depends on e2r_pkg.
`default_nettype none
interface e2r_in_if;
    logic valid;
    logic ready;
    e2r_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface e2r_out_if;
    logic valid;
    logic ready;
    e2r_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/e2r_cordic.sv */
// e2r_cordic: angle fold and pipelined rotation CORDIC, one step per stage.
// Depends on e2r_pkg.
`default_nettype none
module e2r_cordic (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire e2r_pkg::t_angle i_angle,
    output e2r_pkg::t_trig       o_trig
);
    localparam int N = e2r_pkg::N_STEPS;

    logic signed [16:0] w_a;
    logic signed [16:0] w_t;
    logic w_neg;
    e2r_pkg::t_q30 r_x [0:N];
    e2r_pkg::t_q30 r_y [0:N];
    e2r_pkg::t_zang r_z [0:N];
    logic r_neg [0:N];

    always_comb begin
        w_a = 17'(i_angle);
        if (w_a < 0) w_a = w_a + e2r_pkg::DEG360;
        w_neg = 1'b0;
        if (w_a <= e2r_pkg::DEG90) begin
            w_t = w_a;
        end else if (w_a < e2r_pkg::DEG270) begin
            w_t = w_a - e2r_pkg::DEG180;
            w_neg = 1'b1;
        end else begin
            w_t = w_a - e2r_pkg::DEG360;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= e2r_pkg::GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= e2r_pkg::ZW'(w_t) <<< 13;
            r_neg[0] <= w_neg;
            for (int i = 0; i < N; i++) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - e2r_pkg::atan_q20(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + e2r_pkg::atan_q20(i);
                end
            end
        end
    end

    assign o_trig.cs = r_neg[N] ? -r_x[N] : r_x[N];
    assign o_trig.sn = r_neg[N] ? -r_y[N] : r_y[N];
endmodule
`default_nettype wire

/* hdl/e2r_matrix.sv */
// e2r_matrix: three registered stages, multiplies then a final sum and round, forming the nine entries.
// Depends on e2r_pkg.
`default_nettype none
module e2r_matrix (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire e2r_pkg::t_trig   i_yaw,
    input  wire e2r_pkg::t_trig   i_pitch,
    input  wire e2r_pkg::t_trig   i_roll,
    output e2r_pkg::t_out_item    o_item
);
    typedef logic signed [e2r_pkg::CW:0] t_sum;

    e2r_pkg::t_q30 r_cr, r_sr, r_cysp, r_sysp, r_cycp, r_sycp;
    e2r_pkg::t_q30 r_sycr, r_sysr, r_cycr, r_cysr, r_cpsr, r_cpcr, r_sp;
    e2r_pkg::t_q30 r_p1, r_p2, r_p4, r_p5;
    e2r_pkg::t_q30 r_c00, r_c10, r_c21, r_c22, r_m1, r_m2, r_m4, r_m5, r_msp;
    e2r_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cysp <= e2r_pkg::rnd30(i_yaw.cs * i_pitch.sn);
            r_sysp <= e2r_pkg::rnd30(i_yaw.sn * i_pitch.sn);
            r_cycp <= e2r_pkg::rnd30(i_yaw.cs * i_pitch.cs);
            r_sycp <= e2r_pkg::rnd30(i_yaw.sn * i_pitch.cs);
            r_sycr <= e2r_pkg::rnd30(i_yaw.sn * i_roll.cs);
            r_sysr <= e2r_pkg::rnd30(i_yaw.sn * i_roll.sn);
            r_cycr <= e2r_pkg::rnd30(i_yaw.cs * i_roll.cs);
            r_cysr <= e2r_pkg::rnd30(i_yaw.cs * i_roll.sn);
            r_cpsr <= e2r_pkg::rnd30(i_pitch.cs * i_roll.sn);
            r_cpcr <= e2r_pkg::rnd30(i_pitch.cs * i_roll.cs);
            r_sp <= i_pitch.sn;
            r_cr <= i_roll.cs;
            r_sr <= i_roll.sn;

            r_p1 <= e2r_pkg::rnd30(r_cysp * r_sr);
            r_p2 <= e2r_pkg::rnd30(r_cysp * r_cr);
            r_p4 <= e2r_pkg::rnd30(r_sysp * r_sr);
            r_p5 <= e2r_pkg::rnd30(r_sysp * r_cr);
            r_m1 <= r_sycr;
            r_m2 <= r_sysr;
            r_m4 <= r_cycr;
            r_m5 <= r_cysr;
            r_c00 <= r_cycp;
            r_c10 <= r_sycp;
            r_c21 <= r_cpsr;
            r_c22 <= r_cpcr;
            r_msp <= r_sp;

            r_out.r00 <= e2r_pkg::to_q14(t_sum'(r_c00));
            r_out.r01 <= e2r_pkg::to_q14(t_sum'(r_p1) - t_sum'(r_m1));
            r_out.r02 <= e2r_pkg::to_q14(t_sum'(r_p2) + t_sum'(r_m2));
            r_out.r10 <= e2r_pkg::to_q14(t_sum'(r_c10));
            r_out.r11 <= e2r_pkg::to_q14(t_sum'(r_p4) + t_sum'(r_m4));
            r_out.r12 <= e2r_pkg::to_q14(t_sum'(r_p5) - t_sum'(r_m5));
            r_out.r20 <= e2r_pkg::to_q14(-t_sum'(r_msp));
            r_out.r21 <= e2r_pkg::to_q14(t_sum'(r_c21));
            r_out.r22 <= e2r_pkg::to_q14(t_sum'(r_c22));
        end
    end

    assign o_item = r_out;
endmodule
`default_nettype wire

/* hdl/euler_to_rotation_matrix.sv */
// Throughput: one item per cycle; the whole pipeline advances together and
// holds when the output stage is full and not taken.
// Reset clears the valid bits only; data registers are not reset.
// Depends on e2r_pkg, e2r_if, e2r_cordic, e2r_matrix.
`default_nettype none
module euler_to_rotation_matrix (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    e2r_in_if.sink      i_in,
    e2r_out_if.source   o_out
);
    localparam int LAT = e2r_pkg::N_STEPS + 4;

    logic [LAT-1:0] r_vld;
    logic w_en;
    e2r_pkg::t_trig w_yaw, w_pitch, w_roll;

    assign w_en = ~r_vld[LAT-1] | o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    e2r_cordic u_yaw (.i_clk(i_clk), .i_en(w_en), .i_angle(i_in.data.yaw_angle),
                      .o_trig(w_yaw));
    e2r_cordic u_pitch (.i_clk(i_clk), .i_en(w_en), .i_angle(i_in.data.pitch_angle),
                        .o_trig(w_pitch));
    e2r_cordic u_roll (.i_clk(i_clk), .i_en(w_en), .i_angle(i_in.data.roll_angle),
                       .o_trig(w_roll));

    e2r_matrix u_mat (.i_clk(i_clk), .i_en(w_en), .i_yaw(w_yaw), .i_pitch(w_pitch),
                      .i_roll(w_roll), .o_item(o_out.data));

    assign o_out.valid = r_vld[LAT-1];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("output item changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("pipeline stalled with empty output");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.r20 <= e2r_pkg::ONE_Q14 &&
                         o_out.data.r20 >= -e2r_pkg::ONE_Q14))
        else $error("entry out of range");
endmodule
`default_nettype wire
